// ===== hw/rtl/ppmpl_pkg.sv =====
// ============================================================================
// ppmpl_pkg
// Shared types, widths, register indexes and reset values for the PPM
// segment decoder with polarity lock.
// ============================================================================
`default_nettype none

package ppmpl_pkg;

  // Default frame capacity (channels per frame)
  localparam int MAX_CHANNELS_DEF = 12;

  // Field widths
  localparam int DUR_W       = 15;
  localparam int GAP_W       = 16;
  localparam int MINCH_W     = 4;
  localparam int IDX_OUT_W   = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  // Frames that can wait between the decoder front and the result sequencer
  localparam int FRAME_FIFO_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MARKER_MIN  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MARKER_MAX  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MAX = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_GAP    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_CHAN    = 3'd5;

  // Register reset values
  localparam logic [DUR_W-1:0]   MARKER_MIN_RST  = 15'd100;
  localparam logic [DUR_W-1:0]   MARKER_MAX_RST  = 15'd500;
  localparam logic [DUR_W-1:0]   CHANNEL_MIN_RST = 15'd900;
  localparam logic [DUR_W-1:0]   CHANNEL_MAX_RST = 15'd2100;
  localparam logic [DUR_W-1:0]   SYNC_GAP_RST    = 15'd2700;
  localparam logic [MINCH_W-1:0] MIN_CHAN_RST    = 4'd4;

  // Input word
  typedef struct packed {
    logic             segment_level;
    logic [DUR_W-1:0] segment_duration;
    logic             end_of_burst;
  } ppmpl_in_t;

  // Result word
  typedef struct packed {
    logic                 decoded;
    logic [IDX_OUT_W-1:0] channel_index;
    logic [DUR_W-1:0]     pulse_width;
    logic [IDX_OUT_W-1:0] channel_count;
    logic                 marker_polarity_out;
    logic                 last;
  } ppmpl_out_t;

  // Configuration register set
  typedef struct packed {
    logic [DUR_W-1:0]   marker_min_us;
    logic [DUR_W-1:0]   marker_max_us;
    logic [DUR_W-1:0]   channel_min_us;
    logic [DUR_W-1:0]   channel_max_us;
    logic [DUR_W-1:0]   sync_gap_us;
    logic [MINCH_W-1:0] min_channels;
  } ppmpl_cfg_t;

  // Frame header handed from front to back
  typedef struct packed {
    logic decoded;
    logic polarity;
  } ppmpl_frame_hdr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppmpl_lane.sv =====
// ============================================================================
// ppmpl_lane
// One PPM decode lane: marker detection, gap accumulation, channel capture
// and best-frame tracking for a single marker level.
// ============================================================================
`default_nettype none

module ppmpl_lane #(
  parameter int MAX_CHANNELS = ppmpl_pkg::MAX_CHANNELS_DEF,
  parameter bit LEVEL        = 1'b0
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             seg_valid,
  input  wire logic                             seg_level,
  input  wire logic [ppmpl_pkg::DUR_W-1:0]      seg_duration,
  input  wire logic                             burst_end,
  input  wire ppmpl_pkg::ppmpl_cfg_t            cfg,
  output logic [$clog2(MAX_CHANNELS+1)-1:0]     fin_count,
  output logic [MAX_CHANNELS-1:0][ppmpl_pkg::DUR_W-1:0] fin_pulses
);

  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int IW = $clog2(MAX_CHANNELS);
  localparam int KW = (CW > ppmpl_pkg::MINCH_W) ? CW : ppmpl_pkg::MINCH_W;
  localparam int DW = ppmpl_pkg::DUR_W;
  localparam int GW = ppmpl_pkg::GAP_W;

  logic                            have_marker;
  logic [GW-1:0]                   gap_sum;
  logic [CW-1:0]                   count;
  logic [CW-1:0]                   best_count;
  logic [MAX_CHANNELS-1:0][DW-1:0] pulses;
  logic [MAX_CHANNELS-1:0][DW-1:0] best_pulses;

  logic                            have_next;
  logic [GW-1:0]                   gap_next;
  logic [CW-1:0]                   count_next;
  logic [CW-1:0]                   best_count_next;
  logic [MAX_CHANNELS-1:0][DW-1:0] pulses_next;
  logic [MAX_CHANNELS-1:0][DW-1:0] best_pulses_next;

  logic          is_marker;
  logic          gap_is_sync;
  logic          gap_is_chan;
  logic          append;
  logic          copy_best;
  logic          take_final;
  logic [GW:0]   gap_add;
  logic [KW-1:0] min_k;

  assign min_k = KW'(cfg.min_channels);

  // Classify the segment and the gap that it closes
  assign is_marker = seg_valid && (seg_level == LEVEL) &&
                     (seg_duration >= cfg.marker_min_us) &&
                     (seg_duration <= cfg.marker_max_us);
  assign gap_is_sync = gap_sum >= {1'b0, cfg.sync_gap_us};
  assign gap_is_chan = (gap_sum >= {1'b0, cfg.channel_min_us}) &&
                       (gap_sum <= {1'b0, cfg.channel_max_us});
  assign gap_add     = {1'b0, gap_sum} + {2'b00, seg_duration};

  // Segment step: sync, channel append, error or gap accumulation
  always_comb begin
    have_next       = have_marker;
    gap_next        = gap_sum;
    count_next      = count;
    best_count_next = best_count;
    append          = 1'b0;
    copy_best       = 1'b0;
    if (is_marker) begin
      have_next = 1'b1;
      gap_next  = {1'b0, seg_duration};
      if (have_marker) begin
        priority if (gap_is_sync) begin
          if ((KW'(count) >= min_k) && (count > best_count)) begin
            best_count_next = count;
            copy_best       = 1'b1;
          end
          count_next = '0;
        end else if (gap_is_chan) begin
          if (count < CW'(MAX_CHANNELS)) begin
            append     = 1'b1;
            count_next = count + CW'(1);
          end
        end else begin
          count_next = '0;
        end
      end
    end else if (seg_valid && have_marker) begin
      gap_next = gap_add[GW] ? {GW{1'b1}} : gap_add[GW-1:0];
    end
  end

  // Write the appended interval into its slot
  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (append && (count[IW-1:0] == IW'(i))) begin
        pulses_next[i] = gap_sum[DW-1:0];
      end else begin
        pulses_next[i] = pulses[i];
      end
    end
  end

  assign best_pulses_next = copy_best ? pulses : best_pulses;

  // Final offer of the open frame at burst end
  assign take_final = (KW'(count_next) >= min_k) && (count_next > best_count_next);
  assign fin_count  = take_final ? count_next : best_count_next;
  assign fin_pulses = take_final ? pulses_next : best_pulses_next;

  // Advance lane control state; clear it at burst end
  always_ff @(posedge clk) begin
    if (rst) begin
      have_marker <= 1'b0;
      gap_sum     <= '0;
      count       <= '0;
      best_count  <= '0;
    end else if (burst_end) begin
      have_marker <= 1'b0;
      gap_sum     <= '0;
      count       <= '0;
      best_count  <= '0;
    end else begin
      have_marker <= have_next;
      gap_sum     <= gap_next;
      count       <= count_next;
      best_count  <= best_count_next;
    end
  end

  // Hold captured intervals
  always_ff @(posedge clk) begin
    pulses      <= pulses_next;
    best_pulses <= best_pulses_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ppmpl_front.sv =====
// ============================================================================
// ppmpl_front
// Decoder front: configuration registers, the two decode lanes, and the
// lane choice with polarity lock at burst end.
// ============================================================================
`default_nettype none

module ppmpl_front #(
  parameter int MAX_CHANNELS = ppmpl_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   accept,
  input  wire ppmpl_pkg::ppmpl_in_t                   segment,
  input  wire logic                                   cfg_we,
  input  wire logic [ppmpl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [ppmpl_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                        frame_push,
  output ppmpl_pkg::ppmpl_frame_hdr_t                 frame_hdr,
  output logic [$clog2(MAX_CHANNELS+1)-1:0]           frame_count,
  output logic [MAX_CHANNELS-1:0][ppmpl_pkg::DUR_W-1:0] frame_pulses
);

  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int DW = ppmpl_pkg::DUR_W;

  ppmpl_pkg::ppmpl_cfg_t cfg;
  logic                  locked_polarity;
  logic                  polarity_held;

  logic                            seg_valid;
  logic                            burst_end;
  logic [CW-1:0]                   fin_count0;
  logic [CW-1:0]                   fin_count1;
  logic [MAX_CHANNELS-1:0][DW-1:0] fin_pulses0;
  logic [MAX_CHANNELS-1:0][DW-1:0] fin_pulses1;
  logic                            valid0;
  logic                            valid1;
  logic                            chosen;
  logic                            chosen_ok;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.marker_min_us  <= ppmpl_pkg::MARKER_MIN_RST;
      cfg.marker_max_us  <= ppmpl_pkg::MARKER_MAX_RST;
      cfg.channel_min_us <= ppmpl_pkg::CHANNEL_MIN_RST;
      cfg.channel_max_us <= ppmpl_pkg::CHANNEL_MAX_RST;
      cfg.sync_gap_us    <= ppmpl_pkg::SYNC_GAP_RST;
      cfg.min_channels   <= ppmpl_pkg::MIN_CHAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppmpl_pkg::REG_MARKER_MIN:  cfg.marker_min_us  <= cfg_data;
        ppmpl_pkg::REG_MARKER_MAX:  cfg.marker_max_us  <= cfg_data;
        ppmpl_pkg::REG_CHANNEL_MIN: cfg.channel_min_us <= cfg_data;
        ppmpl_pkg::REG_CHANNEL_MAX: cfg.channel_max_us <= cfg_data;
        ppmpl_pkg::REG_SYNC_GAP:    cfg.sync_gap_us    <= cfg_data;
        ppmpl_pkg::REG_MIN_CHAN:
          cfg.min_channels <= cfg_data[ppmpl_pkg::MINCH_W-1:0];
        default: ;
      endcase
    end
  end

  assign seg_valid = accept && (segment.segment_duration != '0);
  assign burst_end = accept && segment.end_of_burst;

  ppmpl_lane #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .LEVEL        (1'b0)
  ) u_lane0 (
    .clk          (clk),
    .rst          (rst),
    .seg_valid    (seg_valid),
    .seg_level    (segment.segment_level),
    .seg_duration (segment.segment_duration),
    .burst_end    (burst_end),
    .cfg          (cfg),
    .fin_count    (fin_count0),
    .fin_pulses   (fin_pulses0)
  );

  ppmpl_lane #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .LEVEL        (1'b1)
  ) u_lane1 (
    .clk          (clk),
    .rst          (rst),
    .seg_valid    (seg_valid),
    .seg_level    (segment.segment_level),
    .seg_duration (segment.segment_duration),
    .burst_end    (burst_end),
    .cfg          (cfg),
    .fin_count    (fin_count1),
    .fin_pulses   (fin_pulses1)
  );

  assign valid0 = fin_count0 != '0;
  assign valid1 = fin_count1 != '0;

  // Pick the winning lane: held polarity first, else the other lane; unlocked, the longer frame (lane 0 on a tie)
  always_comb begin
    chosen    = 1'b0;
    chosen_ok = 1'b0;
    if (polarity_held) begin
      priority if (locked_polarity ? valid1 : valid0) begin
        chosen    = locked_polarity;
        chosen_ok = 1'b1;
      end else if (locked_polarity ? valid0 : valid1) begin
        chosen    = ~locked_polarity;
        chosen_ok = 1'b1;
      end else begin
        chosen_ok = 1'b0;
      end
    end else begin
      priority if (valid0 && valid1) begin
        chosen    = (fin_count0 >= fin_count1) ? 1'b0 : 1'b1;
        chosen_ok = 1'b1;
      end else if (valid0) begin
        chosen_ok = 1'b1;
      end else if (valid1) begin
        chosen    = 1'b1;
        chosen_ok = 1'b1;
      end else begin
        chosen_ok = 1'b0;
      end
    end
  end

  // Lock the winner's polarity
  always_ff @(posedge clk) begin
    if (rst) begin
      locked_polarity <= 1'b0;
      polarity_held   <= 1'b0;
    end else if (burst_end && chosen_ok) begin
      locked_polarity <= chosen;
      polarity_held   <= 1'b1;
    end
  end

  // Frame word toward the queue
  assign frame_push         = burst_end;
  assign frame_hdr.decoded  = chosen_ok;
  assign frame_hdr.polarity = chosen_ok ? chosen : locked_polarity;
  assign frame_count        = chosen_ok ? (chosen ? fin_count1 : fin_count0) : '0;
  assign frame_pulses       = chosen ? fin_pulses1 : fin_pulses0;

endmodule

`default_nettype wire

// ===== hw/rtl/ppmpl_frame_fifo.sv =====
// ============================================================================
// ppmpl_frame_fifo
// Short queue of decoded frames between the decoder front and the result
// sequencer.
// ============================================================================
`default_nettype none

module ppmpl_frame_fifo #(
  parameter int MAX_CHANNELS = ppmpl_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     wr_en,
  input  wire ppmpl_pkg::ppmpl_frame_hdr_t              wr_hdr,
  input  wire logic [$clog2(MAX_CHANNELS+1)-1:0]        wr_count,
  input  wire logic [MAX_CHANNELS-1:0][ppmpl_pkg::DUR_W-1:0] wr_pulses,
  input  wire logic                                     rd_en,
  output logic                                          fifo_full,
  output logic                                          fifo_empty,
  output ppmpl_pkg::ppmpl_frame_hdr_t                   rd_hdr,
  output logic [$clog2(MAX_CHANNELS+1)-1:0]             rd_count,
  output logic [MAX_CHANNELS-1:0][ppmpl_pkg::DUR_W-1:0] rd_pulses
);

  localparam int DEPTH = ppmpl_pkg::FRAME_FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(MAX_CHANNELS + 1);
  localparam int DW    = ppmpl_pkg::DUR_W;

  ppmpl_pkg::ppmpl_frame_hdr_t     hdr_q    [DEPTH];
  logic [CW-1:0]                   count_q  [DEPTH];
  logic [MAX_CHANNELS-1:0][DW-1:0] pulses_q [DEPTH];

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  assign fifo_full  = fill == FW'(DEPTH);
  assign fifo_empty = fill == '0;
  assign do_wr      = wr_en && !fifo_full;
  assign do_rd      = rd_en && !fifo_empty;

  // Store incoming frames
  always_ff @(posedge clk) begin
    if (do_wr) begin
      hdr_q[wr_ptr]    <= wr_hdr;
      count_q[wr_ptr]  <= wr_count;
      pulses_q[wr_ptr] <= wr_pulses;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + FW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - FW'(1);
      end
    end
  end

  assign rd_hdr    = hdr_q[rd_ptr];
  assign rd_count  = count_q[rd_ptr];
  assign rd_pulses = pulses_q[rd_ptr];

endmodule

`default_nettype wire

// ===== hw/rtl/ppmpl_back.sv =====
// ============================================================================
// ppmpl_back
// Result sequencer: walks the head frame into a registered result stage,
// one channel per cycle while the output register is free or popped.
// ============================================================================
`default_nettype none

module ppmpl_back #(
  parameter int MAX_CHANNELS = ppmpl_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     head_valid,
  input  wire ppmpl_pkg::ppmpl_frame_hdr_t              head_hdr,
  input  wire logic [$clog2(MAX_CHANNELS+1)-1:0]        head_count,
  input  wire logic [MAX_CHANNELS-1:0][ppmpl_pkg::DUR_W-1:0] head_pulses,
  output logic                                          head_pop,
  input  wire logic                                     pop,
  output logic                                          empty,
  output ppmpl_pkg::ppmpl_out_t                         result
);

  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int IW = $clog2(MAX_CHANNELS);
  localparam int OW = ppmpl_pkg::IDX_OUT_W;

  logic                  out_valid;
  ppmpl_pkg::ppmpl_out_t out_word;
  logic [IW-1:0]         idx;
  ppmpl_pkg::ppmpl_out_t res;
  logic                  load;

  assign load = head_valid && (!out_valid || pop);

  // Build the next result from the head frame
  always_comb begin
    res.decoded             = head_hdr.decoded;
    res.marker_polarity_out = head_hdr.polarity;
    if (head_hdr.decoded) begin
      res.channel_index = OW'(idx);
      res.pulse_width   = head_pulses[idx];
      res.channel_count = OW'(head_count);
      res.last          = (CW'(idx) + CW'(1)) == head_count;
    end else begin
      res.channel_index = '0;
      res.pulse_width   = '0;
      res.channel_count = '0;
      res.last          = 1'b1;
    end
  end

  assign head_pop = load && res.last;

  // Advance the channel index within the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= res.last ? '0 : idx + IW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= res;
    end
  end

  assign empty  = !out_valid;
  assign result = out_word;

endmodule

`default_nettype wire

// ===== hw/rtl/ppm_segment_decoder_polarity_lock_core.sv =====
// ============================================================================
// ppm_segment_decoder_polarity_lock_core
// Two-polarity PPM frame decoder with polarity lock; emits the chosen
// frame's channels or one failure word per burst.
// ============================================================================
//
//  Channel   Direction  Handshake        Word
//  --------  ---------  ---------------  ------------------------------------
//  segment   in         push / full      level, duration, end of burst
//  result    out        empty / pop      one channel or failure per word
//  config    in         cfg_we           index, data; no back-pressure
//
//  One segment is taken per cycle while full is low; both lanes update in
//  the same cycle. A burst-end segment writes one frame into a two-entry
//  frame queue; the sequencer then drains it at one result word per cycle
//  while the output is free or popped (up to MAX_CHANNELS words per burst),
//  behind a one-word output register. full rises only while the frame queue
//  holds two frames. Synchronous rst clears all control state and resets config.
// ============================================================================
`default_nettype none

module ppm_segment_decoder_polarity_lock_core #(
  parameter int MAX_CHANNELS = ppmpl_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire ppmpl_pkg::ppmpl_in_t               segment,
  output logic                                    empty,
  input  wire logic                               pop,
  output ppmpl_pkg::ppmpl_out_t                   result,
  input  wire logic                               cfg_we,
  input  wire logic [ppmpl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ppmpl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int DW = ppmpl_pkg::DUR_W;

  logic                            accept;
  logic                            frame_push;
  ppmpl_pkg::ppmpl_frame_hdr_t     frame_hdr;
  logic [CW-1:0]                   frame_count;
  logic [MAX_CHANNELS-1:0][DW-1:0] frame_pulses;
  logic                            fifo_full;
  logic                            fifo_empty;
  ppmpl_pkg::ppmpl_frame_hdr_t     head_hdr;
  logic [CW-1:0]                   head_count;
  logic [MAX_CHANNELS-1:0][DW-1:0] head_pulses;
  logic                            head_pop;

  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  ppmpl_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .segment      (segment),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_push   (frame_push),
    .frame_hdr    (frame_hdr),
    .frame_count  (frame_count),
    .frame_pulses (frame_pulses)
  );

  ppmpl_frame_fifo #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (frame_push),
    .wr_hdr     (frame_hdr),
    .wr_count   (frame_count),
    .wr_pulses  (frame_pulses),
    .rd_en      (head_pop),
    .fifo_full  (fifo_full),
    .fifo_empty (fifo_empty),
    .rd_hdr     (head_hdr),
    .rd_count   (head_count),
    .rd_pulses  (head_pulses)
  );

  ppmpl_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!fifo_empty),
    .head_hdr    (head_hdr),
    .head_count  (head_count),
    .head_pulses (head_pulses),
    .head_pop    (head_pop),
    .pop         (pop),
    .empty       (empty),
    .result      (result)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ppmpl_checker.sv =====
// ============================================================================
// ppmpl_checker
// Port-level checks on the result stream of the decoder core.
// ============================================================================
`default_nettype none

module ppmpl_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  empty,
  input wire logic                  pop,
  input wire ppmpl_pkg::ppmpl_out_t result
);

  // Nothing to read right after reset
  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // A failure word stands alone with zero count and index
  a_fail_alone: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.decoded) |->
      (result.last && result.channel_count == '0 && result.channel_index == '0))
    else $error("failure word malformed");

  // The last channel word carries index count-1
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.decoded && result.last) |->
      (result.channel_index ==
       ppmpl_pkg::IDX_OUT_W'(result.channel_count - ppmpl_pkg::IDX_OUT_W'(1))))
    else $error("last word index does not match channel count");

  // Inside a frame the next word follows at once with the next index
  a_next_index: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.last) |=>
      (!empty && result.channel_index ==
       ppmpl_pkg::IDX_OUT_W'($past(result.channel_index) + ppmpl_pkg::IDX_OUT_W'(1))))
    else $error("frame words not contiguous");

  // Polarity and count hold across one frame
  a_frame_stable: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.last) |=>
      (result.marker_polarity_out == $past(result.marker_polarity_out) &&
       result.channel_count == $past(result.channel_count)))
    else $error("polarity or count changed within a frame");

endmodule

bind ppm_segment_decoder_polarity_lock_core ppmpl_checker u_checker (.*);

`default_nettype wire
